>>> hdl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types, widths and helpers for the distance constraint projection core.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int unsigned PARTICLES_DEF = 1024;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 32;
  localparam int LEN_W   = 33;   // length of a separation, below 2^33
  localparam int SQ_W    = 66;   // sum of three squared 33-bit magnitudes
  localparam int DEN_W   = 34;   // divider denominator
  localparam int NUM_W   = 64;   // divider numerator
  localparam int QUO_W   = 32;   // divider quotient
  localparam int STIFF_W = 17;
  localparam int WORD_W  = 128;  // x, y, z, inverse mass

  localparam logic [STIFF_W-1:0] STIFF_ONE  = 17'h1_0000;
  localparam logic [47:0]        ROUND_HALF = 48'h0000_0000_8000;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_PROJECT = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_RD_REQ, S_RD_DATA,
    S_PA_REQ, S_PB_REQ, S_PB_DATA,
    S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT, S_VIOL,
    S_K_MUL, S_K_RND,
    S_WA_MUL, S_WA_DIV, S_WA_WAIT,
    S_WB_MUL, S_WB_DIV, S_WB_WAIT,
    S_DA_MUL, S_DA_DIV, S_DA_WAIT,
    S_DB_MUL, S_DB_DIV, S_DB_WAIT,
    S_UPDATE, S_WR_A, S_WR_B, S_FINISH
  } state_t;

  // Saturate a 35-bit signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (!v[34] && (v[33:31] != 3'b000)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[34] && (v[33:31] != 3'b111)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/dcp_ram.sv
// ----------------------------------------------------------------------------
// dcp_ram
// Single-port particle memory with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module dcp_ram #(
  parameter int unsigned DEPTH = dcp_pkg::PARTICLES_DEF,
  parameter int          AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [dcp_pkg::WORD_W-1:0] wdata,
  output logic [dcp_pkg::WORD_W-1:0] rdata
);
  import dcp_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/dcp_sqrt.sv
// ----------------------------------------------------------------------------
// dcp_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dcp_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dcp_pkg::SQ_W-1:0]  radicand,
  output logic                      done,
  output logic [dcp_pkg::LEN_W-1:0] root
);
  import dcp_pkg::*;

  logic              busy;
  logic [5:0]        cnt;
  logic [SQ_W-1:0]   rad;
  logic [36:0]       rem;
  logic [36:0]       rem_sh;
  logic [36:0]       trial;
  logic              ge;

  assign rem_sh = {rem[34:0], rad[SQ_W-1:SQ_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 6'(LEN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SQ_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[LEN_W-2:0], ge};
    end
  end

endmodule

>>> hdl/dcp_div.sv
// ----------------------------------------------------------------------------
// dcp_div
// Rounding divider: round(num/den), ties up, one quotient bit per cycle.
// The quotient must fit in 32 bits; every caller guarantees that.
// ----------------------------------------------------------------------------
module dcp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dcp_pkg::NUM_W-1:0] num,
  input  logic [dcp_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [dcp_pkg::QUO_W-1:0] quo
);
  import dcp_pkg::*;

  logic             busy;
  logic [5:0]       cnt;
  logic [NUM_W-1:0] biased;
  logic [DEN_W-1:0] den_q;
  logic [35:0]      rem;
  logic [QUO_W-1:0] lo;
  logic [35:0]      rem_sh;
  logic [35:0]      den_x;
  logic             ge;

  // Adding half the denominator up front turns truncation into rounding.
  assign biased = num + NUM_W'(den >> 1);
  assign rem_sh = {rem[34:0], lo[QUO_W-1]};
  assign den_x  = {2'b00, den_q};
  assign ge     = (rem_sh >= den_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 6'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= {4'b0000, biased[NUM_W-1:QUO_W]};
      lo    <= biased[QUO_W-1:0];
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - den_x) : rem_sh;
      lo  <= {lo[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

>>> hdl/distance_constraint_projection_core.sv
// ----------------------------------------------------------------------------
// distance_constraint_projection_core
// Distance constraint projection over a particle memory of Q16.16 positions.
// ----------------------------------------------------------------------------
// A projection is the longest operation: it runs the 33-step square root and
// makes eight passes through the radix-2 rounding divider; one that is skipped
// at the violation step ends after the square root.
// Throughput: one item at a time; the next item is taken once the previous
// one has left the sequencer, while its result may still wait at the output.
// Reset (rst, synchronous) clears the sequencer, the output valid and sets
// stiffness to 1.0; the particle memory is not cleared.
module distance_constraint_projection_core #(
  parameter int unsigned PARTICLES = dcp_pkg::PARTICLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input item.
  input  logic         s_tvalid,
  output logic         s_tready,
  // index_a[9:0], index_b[19:10], rest_len[50:20], pos_x[82:51],
  // pos_y[114:83], pos_z[146:115], weight[178:147], zero fill above.
  input  logic [183:0] s_tdata,
  // command[1:0].
  input  logic [1:0]   s_tuser,
  // Result item.
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_weight[127:96],
  // violation[159:128], skipped[160], zero fill above.
  output logic [167:0] m_tdata,
  // Stiffness register, Q1.16.
  input  logic         stiffness_we,
  input  logic [16:0]  stiffness_wdata
);
  import dcp_pkg::*;

  localparam int AW = $clog2(PARTICLES);

  state_t state, state_next;

  // Input fields as they arrive.
  logic [IDX_W-1:0] in_ia, in_ib;
  logic [30:0]      in_rest;
  logic [31:0]      in_x, in_y, in_z, in_w;
  cmd_t             in_cmd;
  logic             in_ok_a, in_ok_b;
  logic             accept;

  assign in_ia   = s_tdata[9:0];
  assign in_ib   = s_tdata[19:10];
  assign in_rest = s_tdata[50:20];
  assign in_x    = s_tdata[82:51];
  assign in_y    = s_tdata[114:83];
  assign in_z    = s_tdata[146:115];
  assign in_w    = s_tdata[178:147];
  assign in_cmd  = cmd_t'(s_tuser);
  assign in_ok_a = (32'(in_ia) < 32'(PARTICLES));
  assign in_ok_b = (32'(in_ib) < 32'(PARTICLES));
  assign accept  = s_tvalid && s_tready;

  // Captured item.
  logic [AW-1:0]     addr_a, addr_b;
  logic [30:0]       rest;
  logic [WORD_W-1:0] wr_word;

  // Projection datapath.
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [32:0] d  [3];
  logic signed [31:0] na [3];
  logic signed [31:0] nb [3];
  logic [31:0]        wa, wb;
  logic [32:0]        wsum;
  logic [SQ_W-1:0]    sum;
  logic [LEN_W-1:0]   len;
  logic signed [31:0] viol;
  logic [31:0]        s_mag, sam, sbm, qa;
  logic [1:0]         comp;
  logic [65:0]        prod;
  logic [16:0]        stiffness;

  // Result being built.
  logic [31:0] res_x, res_y, res_z, res_w;
  logic        res_skip;

  // Shared multiplier, registered.
  logic [32:0] mul_a, mul_b;
  logic [32:0] d_mag;
  logic [31:0] viol_mag;
  logic [16:0] k_eff;

  // Memory port and arithmetic units.
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic              sqrt_start, sqrt_done;
  logic [LEN_W-1:0]  sqrt_root;
  logic              div_start, div_done;
  logic [DEN_W-1:0]  div_den;
  logic [QUO_W-1:0]  div_quo;
  logic              out_load;

  logic signed [34:0] viol_wide;
  logic               viol_neg, dn;
  logic signed [34:0] pa_ext, pb_ext, qa_ext, qb_ext;

  assign d_mag    = d[comp][32] ? (33'd0 - d[comp]) : d[comp];
  assign viol_mag = viol[31] ? (32'd0 - viol) : viol;
  assign k_eff    = (stiffness > STIFF_ONE) ? STIFF_ONE : stiffness;
  assign viol_neg = viol[31];
  // A's component moves up and B's down when the component's sign and the violation's differ.
  assign dn       = d[comp][32] ^ viol_neg;
  assign viol_wide = $signed({2'b00, len}) - $signed({4'b0000, rest});
  assign pa_ext   = 35'(pa[comp]);
  assign pb_ext   = 35'(pb[comp]);
  assign qa_ext   = $signed({3'b000, qa});
  assign qb_ext   = $signed({3'b000, div_quo});

  dcp_ram #(.DEPTH(PARTICLES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  dcp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  dcp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[NUM_W-1:0]),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, memory port, unit starts and multiplier operands.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = addr_a;
    ram_wdata  = wr_word;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    div_den    = {1'b0, wsum};
    mul_a      = d_mag;
    mul_b      = d_mag;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_cmd)
            CMD_WRITE:   state_next = in_ok_a ? S_WRITE : S_FINISH;
            CMD_READ:    state_next = in_ok_a ? S_RD_REQ : S_FINISH;
            CMD_PROJECT: state_next = (in_ok_a && in_ok_b) ? S_PA_REQ : S_FINISH;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        state_next = S_FINISH;
      end
      S_RD_REQ:  state_next = S_RD_DATA;
      S_RD_DATA: state_next = S_FINISH;
      S_PA_REQ:  state_next = S_PB_REQ;
      S_PB_REQ: begin
        ram_addr   = addr_b;
        state_next = S_PB_DATA;
      end
      S_PB_DATA: state_next = S_SQ_MUL;
      S_SQ_MUL:  state_next = S_SQ_ACC;
      S_SQ_ACC:  state_next = (comp == 2'd2) ? S_SQRT_GO : S_SQ_MUL;
      S_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_next = S_VIOL;
        end
      end
      S_VIOL: begin
        if ((len == '0) || (wsum == '0)) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_K_MUL;
        end
      end
      S_K_MUL: begin
        mul_a      = {1'b0, viol_mag};
        mul_b      = 33'(k_eff);
        state_next = S_K_RND;
      end
      S_K_RND: state_next = S_WA_MUL;
      S_WA_MUL: begin
        mul_a      = {1'b0, s_mag};
        mul_b      = {1'b0, wa};
        state_next = S_WA_DIV;
      end
      S_WA_DIV: begin
        div_start  = 1'b1;
        state_next = S_WA_WAIT;
      end
      S_WA_WAIT: begin
        if (div_done) begin
          state_next = S_WB_MUL;
        end
      end
      S_WB_MUL: begin
        mul_a      = {1'b0, s_mag};
        mul_b      = {1'b0, wb};
        state_next = S_WB_DIV;
      end
      S_WB_DIV: begin
        div_start  = 1'b1;
        state_next = S_WB_WAIT;
      end
      S_WB_WAIT: begin
        if (div_done) begin
          state_next = S_DA_MUL;
        end
      end
      S_DA_MUL: begin
        mul_a      = {1'b0, sam};
        state_next = S_DA_DIV;
      end
      S_DA_DIV: begin
        div_start  = 1'b1;
        div_den    = {1'b0, len};
        state_next = S_DA_WAIT;
      end
      S_DA_WAIT: begin
        if (div_done) begin
          state_next = S_DB_MUL;
        end
      end
      S_DB_MUL: begin
        mul_a      = {1'b0, sbm};
        state_next = S_DB_DIV;
      end
      S_DB_DIV: begin
        div_start  = 1'b1;
        div_den    = {1'b0, len};
        state_next = S_DB_WAIT;
      end
      S_DB_WAIT: begin
        if (div_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: state_next = (comp == 2'd2) ? S_WR_A : S_DA_MUL;
      S_WR_A: begin
        ram_we     = 1'b1;
        ram_wdata  = {wa, na[2], na[1], na[0]};
        state_next = S_WR_B;
      end
      S_WR_B: begin
        ram_we     = 1'b1;
        ram_addr   = addr_b;
        ram_wdata  = {wb, nb[2], nb[1], nb[0]};
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // The result register frees up when the sink takes the old result.
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers, updated as the sequencer walks its states.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (accept) begin
          addr_a   <= AW'(32'(in_ia));
          addr_b   <= AW'(32'(in_ib));
          rest     <= in_rest;
          wr_word  <= {in_w, in_z, in_y, in_x};
          res_x    <= '0;
          res_y    <= '0;
          res_z    <= '0;
          res_w    <= '0;
          viol     <= '0;
          res_skip <= (in_cmd == CMD_PROJECT);
        end
      end
      S_RD_DATA: begin
        res_x <= ram_rdata[31:0];
        res_y <= ram_rdata[63:32];
        res_z <= ram_rdata[95:64];
        res_w <= ram_rdata[127:96];
      end
      S_PB_REQ: begin
        pa[0] <= ram_rdata[31:0];
        pa[1] <= ram_rdata[63:32];
        pa[2] <= ram_rdata[95:64];
        wa    <= ram_rdata[127:96];
      end
      S_PB_DATA: begin
        pb[0] <= ram_rdata[31:0];
        pb[1] <= ram_rdata[63:32];
        pb[2] <= ram_rdata[95:64];
        wb    <= ram_rdata[127:96];
        wsum  <= 33'(wa) + 33'(ram_rdata[127:96]);
        d[0]  <= 33'(pa[0]) - 33'($signed(ram_rdata[31:0]));
        d[1]  <= 33'(pa[1]) - 33'($signed(ram_rdata[63:32]));
        d[2]  <= 33'(pa[2]) - 33'($signed(ram_rdata[95:64]));
        sum   <= '0;
        comp  <= '0;
      end
      S_SQ_ACC: begin
        sum  <= sum + prod;
        comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          len <= sqrt_root;
        end
      end
      S_VIOL: begin
        viol <= sat32(viol_wide);
        res_skip <= (len == '0) || (wsum == '0);
      end
      S_K_RND: s_mag <= 32'((prod[47:0] + ROUND_HALF) >> 16);
      S_WA_WAIT: begin
        if (div_done) begin
          sam <= div_quo;
        end
      end
      S_WB_WAIT: begin
        if (div_done) begin
          sbm <= div_quo;
        end
      end
      S_DA_WAIT: begin
        if (div_done) begin
          qa <= div_quo;
        end
      end
      S_DB_WAIT: begin
        if (div_done) begin
          na[comp] <= sat32(dn ? (pa_ext + qa_ext) : (pa_ext - qa_ext));
          nb[comp] <= sat32(dn ? (pb_ext - qb_ext) : (pb_ext + qb_ext));
        end
      end
      S_UPDATE: comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
      default: ;
    endcase
  end

  // Result register: holds one finished item while the next one is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, res_skip, viol, res_w, res_z, res_y, res_x};
    end
  end

  // Stiffness register; values above 1.0 act as 1.0.
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFF_ONE;
    end else if (stiffness_we) begin
      stiffness <= stiffness_wdata;
    end
  end

endmodule

>>> hdl/dcp_checker.sv
// ----------------------------------------------------------------------------
// dcp_port_checker
// Port-level checks of the distance constraint projection core.
// ----------------------------------------------------------------------------
module dcp_port_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [167:0] m_tdata
);

  // The input is not ready in the cycle after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after an item");

  // A new result only appears when the sequencer was busy the cycle before.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without work");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // No result is pending right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind distance_constraint_projection_core dcp_port_checker u_dcp_port_checker (.*);
